// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lpps_pkg.sv
// ----------------------------------------------------------------------------
// lpps_pkg
// shared constants, types and tables of the line position / pd steering block
// ----------------------------------------------------------------------------
package lpps_pkg;

    localparam int SENSOR_COUNT     = 8;
    localparam int SAMPLE_BITS      = 10;
    localparam int THRESH_BITS      = 10;
    localparam int THRESH_PER_GROUP = 4;
    localparam int GROUP_BITS       = THRESH_PER_GROUP * THRESH_BITS;
    localparam int CMP_BITS         = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
    localparam int IN_TDATA_BITS    = ((SENSOR_COUNT * SAMPLE_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_BITS   = 3;
    localparam int CFG_DATA_BITS    = GROUP_BITS;

    localparam int MASK_BITS        = 8;
    localparam int COUNT_BITS       = $clog2(SENSOR_COUNT + 1);
    localparam int WSUM_BITS        = $clog2(SENSOR_COUNT * (SENSOR_COUNT - 1) + 1);
    localparam int RECIP_SHIFT      = 10;
    localparam int RECIP_BITS       = RECIP_SHIFT + 1;
    localparam int POS_BITS         = 4;
    localparam int QUOT_BITS        = WSUM_BITS + RECIP_BITS + POS_BITS;

    localparam int ERR_BITS         = 5;
    localparam int DIFF_BITS        = ERR_BITS + 1;
    localparam int GAIN_BITS        = 8;
    localparam int PROD_BITS        = 15;
    localparam int RESP_BITS        = 9;
    localparam int SPEED_BITS       = 8;
    localparam int ACUTE_BITS       = 9;
    localparam int LIMIT_BITS       = 8;
    localparam int RUN_BITS         = 8;

    localparam int SPEED_MAX        = 255;
    localparam int ALL_BLACK_MIN    = 5;

    localparam logic [GAIN_BITS-1:0]  GAIN_P_RESET   = 8'd47;
    localparam logic [GAIN_BITS-1:0]  GAIN_D_RESET   = 8'd57;
    localparam logic [POS_BITS-1:0]   TARGET_RESET   = 4'd7;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET    = 8'd15;
    localparam logic [SPEED_BITS-1:0] STRAIGHT_RESET = 8'd200;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_THRESH_LOW     = 3'd0,
        REG_THRESH_HIGH    = 3'd1,
        REG_GAIN_P         = 3'd2,
        REG_GAIN_D         = 3'd3,
        REG_TARGET         = 3'd4,
        REG_ACUTE_LIMIT    = 3'd5,
        REG_STRAIGHT_SPEED = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MERGE  = 4'b0010,
        ST_MULT   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // findings of the lanes after merging
    typedef struct packed {
        logic [SENSOR_COUNT-1:0] mask;
        logic [POS_BITS-1:0]     position;
        logic                    lost;
        logic                    all_black;
    } merge_t;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [RUN_BITS-1:0]        black_run_count;
        logic                       all_black;
        logic                       acute_right;
        logic                       acute_left;
        logic [SPEED_BITS-1:0]      right_speed;
        logic [SPEED_BITS-1:0]      left_speed;
        logic signed [ERR_BITS-1:0] position_error;
        logic [POS_BITS-1:0]        line_position;
        logic [MASK_BITS-1:0]       black_mask;
    } result_t;

    localparam int OUT_BITS       = $bits(result_t);
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    // ceil(2^RECIP_SHIFT / count), exact quotient for every weight sum that can occur
    function automatic logic [RECIP_BITS-1:0] recip_of(input logic [COUNT_BITS-1:0] count);
        logic [RECIP_BITS-1:0] r;
        case (count)
            COUNT_BITS'(1): r = RECIP_BITS'(1024);
            COUNT_BITS'(2): r = RECIP_BITS'(512);
            COUNT_BITS'(3): r = RECIP_BITS'(342);
            COUNT_BITS'(4): r = RECIP_BITS'(256);
            COUNT_BITS'(5): r = RECIP_BITS'(205);
            COUNT_BITS'(6): r = RECIP_BITS'(171);
            COUNT_BITS'(7): r = RECIP_BITS'(147);
            COUNT_BITS'(8): r = RECIP_BITS'(128);
            default:        r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/lpps_lane.sv
// ----------------------------------------------------------------------------
// lpps_lane
// one sensor lane: black when the sample is below its threshold
// ----------------------------------------------------------------------------
module lpps_lane (
    input  logic [lpps_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [lpps_pkg::THRESH_BITS-1:0] threshold,
    output logic                             black
);
    import lpps_pkg::*;

    logic [CMP_BITS-1:0] sample_ext;
    logic [CMP_BITS-1:0] threshold_ext;

    assign sample_ext    = CMP_BITS'(sample);
    assign threshold_ext = CMP_BITS'(threshold);
    assign black         = (sample_ext < threshold_ext);

endmodule

// File: sv/lpps_merge.sv
// ----------------------------------------------------------------------------
// lpps_merge
// combines lane results: count, weight sum and mean position
// ----------------------------------------------------------------------------
module lpps_merge (
    input  logic [lpps_pkg::SENSOR_COUNT-1:0] black,
    output lpps_pkg::merge_t                  merged
);
    import lpps_pkg::*;

    logic [COUNT_BITS-1:0] count;
    logic [WSUM_BITS-1:0]  wsum;
    logic [QUOT_BITS-1:0]  quot_full;

    always_comb
    begin
        count = '0;
        wsum  = '0;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            count = count + COUNT_BITS'(black[i]);
            wsum  = wsum + (black[i] ? WSUM_BITS'(2 * i) : WSUM_BITS'(0));
        end
    end

    // mean by reciprocal multiply, zero count gives zero
    assign quot_full = QUOT_BITS'(wsum) * QUOT_BITS'(recip_of(count));

    assign merged.mask      = black;
    assign merged.position  = quot_full[RECIP_SHIFT +: POS_BITS];
    assign merged.lost      = (count == '0);
    assign merged.all_black = (count > COUNT_BITS'(ALL_BLACK_MIN));

endmodule

// File: sv/lpps_pd.sv
// ----------------------------------------------------------------------------
// lpps_pd
// pd correction: registered products, clamp and differential wheel speeds
// ----------------------------------------------------------------------------
module lpps_pd (
    input  logic                                    clk,
    input  logic                                    load,
    input  logic signed [lpps_pkg::ERR_BITS-1:0]    err,
    input  logic signed [lpps_pkg::ERR_BITS-1:0]    prev_err,
    input  logic [lpps_pkg::GAIN_BITS-1:0]          gain_p,
    input  logic [lpps_pkg::GAIN_BITS-1:0]          gain_d,
    input  logic [lpps_pkg::SPEED_BITS-1:0]         straight_speed,
    output logic [lpps_pkg::SPEED_BITS-1:0]         left_speed,
    output logic [lpps_pkg::SPEED_BITS-1:0]         right_speed
);
    import lpps_pkg::*;

    logic signed [DIFF_BITS-1:0] diff;
    logic signed [PROD_BITS-1:0] gain_p_ext;
    logic signed [PROD_BITS-1:0] gain_d_ext;
    logic signed [PROD_BITS-1:0] err_ext;
    logic signed [PROD_BITS-1:0] diff_ext;
    logic signed [PROD_BITS-1:0] prod_p_reg;
    logic signed [PROD_BITS-1:0] prod_p_next;
    logic signed [PROD_BITS-1:0] prod_d_reg;
    logic signed [PROD_BITS-1:0] prod_d_next;
    logic signed [PROD_BITS-1:0] corr;
    logic signed [RESP_BITS-1:0] resp;
    logic        [RESP_BITS-1:0] speed_wide;

    assign diff       = {err[ERR_BITS-1], err} - {prev_err[ERR_BITS-1], prev_err};
    assign gain_p_ext = {{(PROD_BITS-GAIN_BITS){1'b0}}, gain_p};
    assign gain_d_ext = {{(PROD_BITS-GAIN_BITS){1'b0}}, gain_d};
    assign err_ext    = {{(PROD_BITS-ERR_BITS){err[ERR_BITS-1]}}, err};
    assign diff_ext   = {{(PROD_BITS-DIFF_BITS){diff[DIFF_BITS-1]}}, diff};

    assign prod_p_next = gain_p_ext * err_ext;
    assign prod_d_next = gain_d_ext * diff_ext;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_p_reg <= prod_p_next;
            prod_d_reg <= prod_d_next;
        end
    end

    assign corr = prod_p_reg + prod_d_reg;

    // clamp to +-SPEED_MAX
    always_comb
    begin
        if (corr > PROD_BITS'(SPEED_MAX))
            resp = RESP_BITS'(SPEED_MAX);
        else if (corr < -PROD_BITS'(SPEED_MAX))
            resp = -RESP_BITS'(SPEED_MAX);
        else
            resp = corr[RESP_BITS-1:0];
    end

    always_comb
    begin
        speed_wide = '0;
        if (resp > 0)
        begin
            speed_wide  = RESP_BITS'(SPEED_MAX) - resp;
            left_speed  = speed_wide[SPEED_BITS-1:0];
            right_speed = SPEED_BITS'(SPEED_MAX);
        end
        else if (resp < 0)
        begin
            speed_wide  = RESP_BITS'(SPEED_MAX) + resp;
            left_speed  = SPEED_BITS'(SPEED_MAX);
            right_speed = speed_wide[SPEED_BITS-1:0];
        end
        else
        begin
            left_speed  = straight_speed;
            right_speed = straight_speed;
        end
    end

endmodule

// File: sv/line_position_pd_steering.sv
// ----------------------------------------------------------------------------
// line_position_pd_steering
// line position from a reflectance array and pd steering of two wheels
// ----------------------------------------------------------------------------
// Each input word is one frame of eight reflectance samples; each output word
// is the steering result of that frame. Until its result stands in the output
// register, a frame passes through the accepting cycle, in which the eight
// sensor lanes compare their samples against the thresholds, the merge step,
// in which the merge stage forms the black count, the weight sum and the mean
// position (a reciprocal-table multiply), the multiply step, in which the pd
// unit registers its two gain products, and the finish step, in which the
// clamp, the wheel speeds and the frame state (acute marks, black run, and,
// when the line is seen, previous error and held speeds) are updated. The next
// frame is taken in the cycle after that; the sequencer accepts only while
// idle, so each frame passes through the single pd unit before the next. A
// finished word waits in the output register while the next frame is taken;
// the last stage stalls only if the previous word has still not been taken.
// Register writes are expected only while no frame is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_position_pd_steering (
    input  logic                                    clk,
    input  logic                                    rst_n,

    // configuration write port
    input  logic                                    cfg_write_en,
    input  logic [lpps_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [lpps_pkg::CFG_DATA_BITS-1:0]      cfg_data,

    // frame input
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // sample_0 [9:0], sample_1 [19:10], ... sample_7 [79:70]
    input  logic [lpps_pkg::IN_TDATA_BITS-1:0]      s_tdata,

    // result output
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // black_mask [7:0], line_position [11:8], position_error [16:12],
    // left_speed [24:17], right_speed [32:25], acute_left [33],
    // acute_right [34], all_black [35], black_run_count [43:36], zero pad
    output logic [lpps_pkg::OUT_TDATA_BITS-1:0]     m_tdata,
    // line_lost [0]
    output logic                                    m_tuser
);
    import lpps_pkg::*;

    // configuration registers
    logic [GROUP_BITS-1:0]  thresh_low_reg;
    logic [GROUP_BITS-1:0]  thresh_high_reg;
    logic [GAIN_BITS-1:0]   gain_p_reg;
    logic [GAIN_BITS-1:0]   gain_d_reg;
    logic [POS_BITS-1:0]    target_reg;
    logic [LIMIT_BITS-1:0]  limit_reg;
    logic [SPEED_BITS-1:0]  straight_reg;

    // sequencer
    state_t                 state_reg;
    state_t                 state_next;

    // frame pipeline payload
    logic [SENSOR_COUNT-1:0] black_lane;
    logic [SENSOR_COUNT-1:0] black_reg;
    merge_t                  merge_comb;
    merge_t                  merge_reg;
    logic signed [ERR_BITS-1:0] err;
    logic [SPEED_BITS-1:0]   pd_left;
    logic [SPEED_BITS-1:0]   pd_right;

    // frame state
    logic signed [ERR_BITS-1:0] prev_error_reg;
    logic signed [ERR_BITS-1:0] prev_error_next;
    logic [SPEED_BITS-1:0]   held_left_reg;
    logic [SPEED_BITS-1:0]   held_left_next;
    logic [SPEED_BITS-1:0]   held_right_reg;
    logic [SPEED_BITS-1:0]   held_right_next;
    logic                    mark_left_reg;
    logic                    mark_left_next;
    logic                    mark_right_reg;
    logic                    mark_right_next;
    logic [ACUTE_BITS-1:0]   acute_count_reg;
    logic [ACUTE_BITS-1:0]   acute_count_next;
    logic [RUN_BITS-1:0]     black_run_reg;
    logic [RUN_BITS-1:0]     black_run_next;

    // acute latch update for the frame in the last stage
    logic                    outer_left;
    logic                    outer_right;
    logic                    upd_mark_left;
    logic                    upd_mark_right;
    logic [ACUTE_BITS-1:0]   upd_acute_count;
    logic [RUN_BITS-1:0]     upd_black_run;

    // output register
    logic                    m_tvalid_reg;
    logic                    m_tvalid_next;
    result_t                 out_reg;
    result_t                 out_next;
    logic                    out_lost_reg;
    logic                    finish_fire;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_low_reg  <= '0;
            thresh_high_reg <= '0;
            gain_p_reg      <= GAIN_P_RESET;
            gain_d_reg      <= GAIN_D_RESET;
            target_reg      <= TARGET_RESET;
            limit_reg       <= LIMIT_RESET;
            straight_reg    <= STRAIGHT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_THRESH_LOW:     thresh_low_reg  <= cfg_data[GROUP_BITS-1:0];
                REG_THRESH_HIGH:    thresh_high_reg <= cfg_data[GROUP_BITS-1:0];
                REG_GAIN_P:         gain_p_reg      <= cfg_data[GAIN_BITS-1:0];
                REG_GAIN_D:         gain_d_reg      <= cfg_data[GAIN_BITS-1:0];
                REG_TARGET:         target_reg      <= cfg_data[POS_BITS-1:0];
                REG_ACUTE_LIMIT:    limit_reg       <= cfg_data[LIMIT_BITS-1:0];
                REG_STRAIGHT_SPEED: straight_reg    <= cfg_data[SPEED_BITS-1:0];
                default:            ;   // unknown index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sensor lanes: one comparator per sensor, thresholds from two groups
    // ------------------------------------------------------------------
    for (genvar i = 0; i < SENSOR_COUNT; i++)
    begin : g_lane
        localparam int  GRP_OFS = (i % THRESH_PER_GROUP) * THRESH_BITS;
        localparam bit  IN_HIGH = (i >= THRESH_PER_GROUP);

        logic [THRESH_BITS-1:0] lane_threshold;

        assign lane_threshold = IN_HIGH ? thresh_high_reg[GRP_OFS +: THRESH_BITS]
                                        : thresh_low_reg[GRP_OFS +: THRESH_BITS];

        lpps_lane u_lane (
            .sample    (s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]),
            .threshold (lane_threshold),
            .black     (black_lane[i])
        );
    end

    // lane results captured with the accepted word
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            black_reg <= black_lane;
    end

    // ------------------------------------------------------------------
    // merge stage
    // ------------------------------------------------------------------
    lpps_merge u_merge (
        .black  (black_reg),
        .merged (merge_comb)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MERGE)
            merge_reg <= merge_comb;
    end

    // error against the wanted position, fits in five signed bits
    assign err = ERR_BITS'({1'b0, target_reg}) - ERR_BITS'({1'b0, merge_reg.position});

    // ------------------------------------------------------------------
    // pd unit: products registered in the multiply cycle
    // ------------------------------------------------------------------
    lpps_pd u_pd (
        .clk            (clk),
        .load           (state_reg == ST_MULT),
        .err            (err),
        .prev_err       (prev_error_reg),
        .gain_p         (gain_p_reg),
        .gain_d         (gain_d_reg),
        .straight_speed (straight_reg),
        .left_speed     (pd_left),
        .right_speed    (pd_right)
    );

    // ------------------------------------------------------------------
    // acute marks and black run of the frame in the last stage
    // ------------------------------------------------------------------
    assign outer_left  = merge_reg.mask[0];
    assign outer_right = merge_reg.mask[SENSOR_COUNT-1];

    always_comb
    begin
        upd_mark_left   = mark_left_reg;
        upd_mark_right  = mark_right_reg;
        upd_acute_count = acute_count_reg;
        if (outer_left || outer_right)
        begin
            // outer sensor on the line: marks follow the outer readings
            upd_mark_left  = outer_left;
            upd_mark_right = outer_right;
        end
        else if (!merge_reg.lost && (mark_left_reg || mark_right_reg))
        begin
            if (acute_count_reg != '1)
                upd_acute_count = acute_count_reg + 1'b1;
        end
        // count past the limit clears the marks
        if (upd_acute_count > ACUTE_BITS'(limit_reg))
        begin
            upd_mark_left   = 1'b0;
            upd_mark_right  = 1'b0;
            upd_acute_count = '0;
        end

        if (merge_reg.all_black)
            upd_black_run = (black_run_reg != '1) ? black_run_reg + 1'b1 : black_run_reg;
        else
            upd_black_run = '0;
    end

    // ------------------------------------------------------------------
    // sequencer and frame state
    // ------------------------------------------------------------------
    assign s_tready    = (state_reg == ST_IDLE);
    assign finish_fire = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next       = state_reg;
        prev_error_next  = prev_error_reg;
        held_left_next   = held_left_reg;
        held_right_next  = held_right_reg;
        mark_left_next   = mark_left_reg;
        mark_right_next  = mark_right_reg;
        acute_count_next = acute_count_reg;
        black_run_next   = black_run_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (finish_fire)
                begin
                    // lost line: pd step skipped, speeds and error held
                    if (!merge_reg.lost)
                    begin
                        prev_error_next = err;
                        held_left_next  = pd_left;
                        held_right_next = pd_right;
                    end
                    mark_left_next   = upd_mark_left;
                    mark_right_next  = upd_mark_right;
                    acute_count_next = upd_acute_count;
                    black_run_next   = upd_black_run;
                    m_tvalid_next    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            prev_error_reg  <= '0;
            held_left_reg   <= '0;
            held_right_reg  <= '0;
            mark_left_reg   <= 1'b0;
            mark_right_reg  <= 1'b0;
            acute_count_reg <= '0;
            black_run_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            prev_error_reg  <= prev_error_next;
            held_left_reg   <= held_left_next;
            held_right_reg  <= held_right_next;
            mark_left_reg   <= mark_left_next;
            mark_right_reg  <= mark_right_next;
            acute_count_reg <= acute_count_next;
            black_run_reg   <= black_run_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_next.black_mask      = MASK_BITS'(merge_reg.mask);
        out_next.line_position   = merge_reg.position;
        out_next.position_error  = prev_error_next;
        out_next.left_speed      = held_left_next;
        out_next.right_speed     = held_right_next;
        out_next.acute_left      = upd_mark_left;
        out_next.acute_right     = upd_mark_right;
        out_next.all_black       = merge_reg.all_black;
        out_next.black_run_count = upd_black_run;
    end

    always_ff @(posedge clk)
    begin
        if (finish_fire)
        begin
            out_reg      <= out_next;
            out_lost_reg <= merge_reg.lost;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_BITS'(out_reg);
    assign m_tuser  = out_lost_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_accept_to_merge, s_tvalid && s_tready, state_reg == ST_MERGE,
        "accepted frame did not move to the merge stage")
    `ASSERT_NEXT(a_out_held, (state_reg == ST_FINISH) && m_tvalid_reg && !m_tready,
        (state_reg == ST_FINISH) && $stable(out_reg) && m_tvalid_reg,
        "waiting result word was overwritten")
    `ASSERT_SAME(a_lost_position, m_tvalid_reg && out_lost_reg,
        out_reg.line_position == '0,
        "lost line reported with a nonzero position")
    `ASSERT_SAME(a_speed_shape, 1'b1,
        (held_left_reg == SPEED_BITS'(SPEED_MAX)) || (held_right_reg == SPEED_BITS'(SPEED_MAX))
        || (held_left_reg == held_right_reg),
        "held wheel speeds neither differential nor straight")

endmodule

// File: dv/line_position_pd_steering_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_position_pd_steering_checker
// watches the register port and both streams, predicts every result word
// ----------------------------------------------------------------------------
module line_position_pd_steering_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [lpps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lpps_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [lpps_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [lpps_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
    input  logic                                 m_tuser,
    output int                                   fail_count,
    output int                                   outstanding,
    output int                                   words_checked,
    output int                                   lost_words,
    output int                                   all_black_words
);
    import lpps_pkg::*;

    typedef logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] frame_t;

    // register copy
    frame_t                thr_q;
    logic [GAIN_BITS-1:0]  gain_p_q;
    logic [GAIN_BITS-1:0]  gain_d_q;
    logic [POS_BITS-1:0]   target_q;
    logic [LIMIT_BITS-1:0] limit_q;
    logic [SPEED_BITS-1:0] straight_q;

    // steering state
    int                    last_err;
    int                    shown_err;
    logic                  mark_l;
    logic                  mark_r;
    int                    acute_cnt;
    int                    run_cnt;
    logic [SPEED_BITS-1:0] hold_left;
    logic [SPEED_BITS-1:0] hold_right;

    result_t               steer_words[$];
    logic                  lost_flags[$];

    function automatic void check_field(input string field, input int want, input int seen);
        if (want != seen) begin
            $error("%s: expected %0d, got %0d", field, want, seen);
            fail_count++;
        end
    endfunction

    task automatic steer_frame(input frame_t smp, output result_t r, output logic lost);
        logic [SENSOR_COUNT-1:0] mask;
        int                      wsum;
        int                      cnt;
        int                      pos;
        int                      err;
        int                      corr;
        mask = '0;
        wsum = 0;
        cnt  = 0;
        pos  = 0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (smp[i] < thr_q[i]) begin
                mask[i] = 1'b1;
                wsum   += 2 * i;
                cnt++;
            end
        end
        lost = (cnt == 0);
        if (!lost)
            pos = wsum / cnt;

        // outer sensors reload both marks, otherwise a seen line ages them
        if (mask[0] || mask[SENSOR_COUNT-1]) begin
            mark_l = mask[0];
            mark_r = mask[SENSOR_COUNT-1];
        end
        else if (!lost && (mark_l || mark_r) && acute_cnt < 511) begin
            acute_cnt++;
        end
        if (acute_cnt > int'(limit_q)) begin
            mark_l    = 1'b0;
            mark_r    = 1'b0;
            acute_cnt = 0;
        end

        if (cnt > ALL_BLACK_MIN) begin
            if (run_cnt < 255)
                run_cnt++;
        end
        else begin
            run_cnt = 0;
        end

        if (!lost) begin
            err       = int'(target_q) - pos;
            corr      = int'(gain_p_q) * err + int'(gain_d_q) * (err - last_err);
            last_err  = err;
            shown_err = err;
            if (corr > SPEED_MAX)
                corr = SPEED_MAX;
            if (corr < -SPEED_MAX)
                corr = -SPEED_MAX;
            if (corr > 0) begin
                hold_right = SPEED_BITS'(SPEED_MAX);
                hold_left  = SPEED_BITS'(SPEED_MAX - corr);
            end
            else if (corr < 0) begin
                hold_right = SPEED_BITS'(SPEED_MAX + corr);
                hold_left  = SPEED_BITS'(SPEED_MAX);
            end
            else begin
                hold_left  = straight_q;
                hold_right = straight_q;
            end
        end

        r.black_mask      = MASK_BITS'(mask);
        r.line_position   = POS_BITS'(pos);
        r.position_error  = ERR_BITS'(shown_err);
        r.left_speed      = hold_left;
        r.right_speed     = hold_right;
        r.acute_left      = mark_l;
        r.acute_right     = mark_r;
        r.all_black       = (cnt > ALL_BLACK_MIN);
        r.black_run_count = RUN_BITS'(run_cnt);
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        result_t want_w;
        result_t got_w;
        logic    want_lost;
        int      delta;
        if (!rst_n) begin
            thr_q           = '0;
            gain_p_q        = GAIN_P_RESET;
            gain_d_q        = GAIN_D_RESET;
            target_q        = TARGET_RESET;
            limit_q         = LIMIT_RESET;
            straight_q      = STRAIGHT_RESET;
            last_err        = 0;
            shown_err       = 0;
            mark_l          = 1'b0;
            mark_r          = 1'b0;
            acute_cnt       = 0;
            run_cnt         = 0;
            hold_left       = '0;
            hold_right      = '0;
            steer_words.delete();
            lost_flags.delete();
            fail_count      = 0;
            words_checked   = 0;
            lost_words      = 0;
            all_black_words = 0;
            outstanding    <= 0;
        end
        else begin
            delta = 0;
            if (cfg_write_en) begin
                case (cfg_index)
                    REG_THRESH_LOW:     thr_q[3:0] = cfg_data;
                    REG_THRESH_HIGH:    thr_q[7:4] = cfg_data;
                    REG_GAIN_P:         gain_p_q   = cfg_data[GAIN_BITS-1:0];
                    REG_GAIN_D:         gain_d_q   = cfg_data[GAIN_BITS-1:0];
                    REG_TARGET:         target_q   = cfg_data[POS_BITS-1:0];
                    REG_ACUTE_LIMIT:    limit_q    = cfg_data[LIMIT_BITS-1:0];
                    REG_STRAIGHT_SPEED: straight_q = cfg_data[SPEED_BITS-1:0];
                    default:            ;
                endcase
            end

            // result side first, so a word never meets its own frame
            if (m_tvalid && m_tready) begin
                got_w = result_t'(m_tdata[OUT_BITS-1:0]);
                if (steer_words.size() == 0) begin
                    $error("result word with no frame waiting: %h", m_tdata);
                    fail_count++;
                end
                else begin
                    want_w    = steer_words.pop_front();
                    want_lost = lost_flags.pop_front();
                    delta--;
                    words_checked++;
                    if (want_lost)
                        lost_words++;
                    if (want_w.all_black)
                        all_black_words++;
                    check_field("black_mask", int'(want_w.black_mask),
                                int'(got_w.black_mask));
                    check_field("line_position", int'(want_w.line_position),
                                int'(got_w.line_position));
                    check_field("line_lost", int'(want_lost), int'(m_tuser));
                    check_field("position_error", int'($signed(want_w.position_error)),
                                int'($signed(got_w.position_error)));
                    check_field("left_speed", int'(want_w.left_speed),
                                int'(got_w.left_speed));
                    check_field("right_speed", int'(want_w.right_speed),
                                int'(got_w.right_speed));
                    check_field("acute_left", int'(want_w.acute_left),
                                int'(got_w.acute_left));
                    check_field("acute_right", int'(want_w.acute_right),
                                int'(got_w.acute_right));
                    check_field("all_black", int'(want_w.all_black),
                                int'(got_w.all_black));
                    check_field("black_run_count", int'(want_w.black_run_count),
                                int'(got_w.black_run_count));
                end
            end

            if (s_tvalid && s_tready) begin
                steer_frame(frame_t'(s_tdata[SENSOR_COUNT*SAMPLE_BITS-1:0]), want_w, want_lost);
                steer_words.push_back(want_w);
                lost_flags.push_back(want_lost);
                delta++;
            end
            outstanding <= outstanding + delta;
        end
    end

endmodule

// File: dv/line_position_pd_steering_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_position_pd_steering_tb
// frame stimulus, register settings and verdict for the steering block
// ----------------------------------------------------------------------------
// A directed opening checks the reset defaults, threshold edges, each single
// sensor, truncated means and both clamp directions; then several register
// settings each carry a stream of line-shaped frames with some noise. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module line_position_pd_steering_tb;
    import lpps_pkg::*;

    typedef logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] frame_t;

    // index past the register list, writes to it must be ignored
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam int RANDOM_FRAMES = 125;   // per setting of the loop
    localparam int BLACK_STRETCH = 270;   // enough to saturate the black run count

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tuser;

    int fail_count;
    int outstanding;
    int words_checked;
    int lost_words;
    int all_black_words;

    // thresholds as last written, used to shape samples
    frame_t thr = '0;
    int     line_at = 3;
    int     settings_seen = 0;

    always #10 clk = ~clk;

    line_position_pd_steering dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    line_position_pd_steering_checker steer_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .words_checked   (words_checked),
        .lost_words      (lost_words),
        .all_black_words (all_black_words)
    );

    // receiver: switches between free running, light, heavy and near-blocked stalls
    int rdy_mode = 0;
    int rdy_left = 0;

    always @(posedge clk) begin
        if (rdy_left == 0) begin
            rdy_mode <= $urandom_range(3, 0);
            rdy_left <= $urandom_range(200, 20);
        end
        else begin
            rdy_left <= rdy_left - 1;
        end
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(3, 0) != 0);
            2:       m_tready <= ($urandom_range(3, 0) == 0);
            default: m_tready <= ($urandom_range(9, 0) == 0);
        endcase
    end

    // one register write, then the enable is dropped before the task returns, so it is never re-raised in the same step
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input frame_t t, input logic [7:0] gp, input logic [7:0] gd,
                                 input logic [3:0] tgt, input logic [7:0] lim,
                                 input logic [7:0] spd);
        thr = t;
        write_reg(REG_THRESH_LOW, t[3:0]);
        write_reg(REG_THRESH_HIGH, t[7:4]);
        write_reg(REG_GAIN_P, CFG_DATA_BITS'(gp));
        write_reg(REG_GAIN_D, CFG_DATA_BITS'(gd));
        write_reg(REG_TARGET, CFG_DATA_BITS'(tgt));
        write_reg(REG_ACUTE_LIMIT, CFG_DATA_BITS'(lim));
        write_reg(REG_STRAIGHT_SPEED, CFG_DATA_BITS'(spd));
        settings_seen++;
    endtask

    // word held until the block takes it; valid left high for a following word
    task automatic send_frame(input frame_t f);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_BITS'(f);
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic pause(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // hold off until every predicted word has come back, then let the pipe empty
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (6) @(posedge clk);
    endtask

    // samples below threshold where a black sensor is wanted, at or above it elsewhere
    function automatic frame_t paint(input logic [SENSOR_COUNT-1:0] want);
        frame_t f;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (want[i] && thr[i] != 0)
                f[i] = ($urandom_range(3, 0) == 0) ? '0
                       : SAMPLE_BITS'($urandom_range(thr[i] - 1, 0));
            else
                f[i] = ($urandom_range(3, 0) == 0) ? '1
                       : SAMPLE_BITS'($urandom_range(1023, thr[i]));
        end
        return f;
    endfunction

    task automatic send_mask(input logic [SENSOR_COUNT-1:0] want);
        send_frame(paint(want));
    endtask

    // mostly a line wandering across the array, sometimes wide, lost or noise
    function automatic frame_t random_frame();
        frame_t                  f;
        logic [SENSOR_COUNT-1:0] m;
        int                      kind;
        int                      w;
        kind = $urandom_range(19, 0);
        if (kind >= 17) begin
            for (int i = 0; i < SENSOR_COUNT; i++)
                f[i] = SAMPLE_BITS'($urandom_range(1023, 0));
            return f;
        end
        if (kind <= 12) begin
            line_at += int'($urandom_range(2, 0)) - 1;
            if (line_at < 0)
                line_at = 0;
            if (line_at > SENSOR_COUNT - 1)
                line_at = SENSOR_COUNT - 1;
            w = $urandom_range(3, 1);
            m = SENSOR_COUNT'(((1 << w) - 1) << line_at);
        end
        else if (kind <= 14) begin
            w = $urandom_range(SENSOR_COUNT, 6);
            m = SENSOR_COUNT'(((1 << w) - 1) << $urandom_range(SENSOR_COUNT - w, 0));
        end
        else if (kind == 15) begin
            m = '0;
        end
        else begin
            m = SENSOR_COUNT'($urandom_range(255, 0));
        end
        return paint(m);
    endfunction

    function automatic frame_t random_thresholds();
        frame_t t;
        for (int i = 0; i < SENSOR_COUNT; i++)
            t[i] = SAMPLE_BITS'($urandom_range(1023, 1));
        return t;
    endfunction

    initial begin : stimulus
        frame_t mid;
        int     burst_left;
        mid        = {SENSOR_COUNT{10'd512}};
        burst_left = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds are zero: nothing reads black, speeds and error stay at reset
        send_frame('0);
        send_frame('1);
        drain();

        apply_setting(mid, 8'd47, 8'd57, 4'd7, 8'd3, 8'd200);
        write_reg(REG_UNUSED, '1);

        // sample edges: all zero, all full scale, exactly at and just below threshold
        send_frame({SENSOR_COUNT{10'd0}});
        send_frame({SENSOR_COUNT{10'd1023}});
        send_frame({SENSOR_COUNT{10'd512}});
        send_frame({SENSOR_COUNT{10'd511}});
        // centred pair gives zero error: straight speed
        send_mask(8'b0001_1000);
        // each sensor alone, the outer ones latch marks, the inner ones age them
        for (int i = 0; i < SENSOR_COUNT; i++)
            send_mask(SENSOR_COUNT'(1 << i));
        send_mask(8'b1000_0001);
        send_mask(8'b0011_1111);
        send_mask(8'b0001_1111);
        // mean of 0, 2 and 6 truncates
        send_mask(8'b0000_1011);
        drain();

        // largest gains, target beyond fourteen: clamp on the positive side
        apply_setting(mid, 8'd255, 8'd255, 4'd15, 8'd0, 8'd0);
        send_mask(8'h80);
        send_mask(8'h01);
        drain();
        // target at the left end: clamp on the negative side
        write_reg(REG_TARGET, CFG_DATA_BITS'(0));
        send_mask(8'h80);
        send_mask(8'h01);

        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                0:       apply_setting({SENSOR_COUNT{10'd1023}}, 8'd255, 8'd0, 4'd15,
                                       8'd255, 8'd255);
                1:       apply_setting(random_thresholds(), 8'd0, 8'd255, 4'd0, 8'd0, 8'd0);
                default: apply_setting(random_thresholds(), 8'($urandom_range(255, 0)),
                                       8'($urandom_range(255, 0)), 4'($urandom_range(15, 0)),
                                       8'($urandom_range(20, 0)), 8'($urandom_range(255, 0)));
            endcase

            // unbroken run of wide frames, no gaps, to saturate the black run count
            if (p == 2) begin
                for (int n = 0; n < BLACK_STRETCH; n++)
                    send_mask(8'hFF);
            end

            for (int n = 0; n < RANDOM_FRAMES; n++) begin
                if (burst_left == 0) begin
                    pause(($urandom_range(3, 0) == 0) ? $urandom_range(40, 9)
                                                      : $urandom_range(8, 1));
                    burst_left = $urandom_range(24, 1);
                end
                burst_left--;
                send_frame(random_frame());
            end
        end

        drain();
        repeat (8) @(posedge clk);

        $display("run: %0d frames over %0d register settings, %0d with the line lost,",
                 words_checked, settings_seen, lost_words);
        $display("     %0d all-black, outer marks and both clamp directions exercised",
                 all_black_words);
        if (fail_count == 0 && outstanding == 0)
            $display("line_position_pd_steering verification clean");
        else
            $display("line_position_pd_steering verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #(64'd20_000_000);
        $display("line_position_pd_steering verification failed");
        $finish;
    end

endmodule
